>>> rtl/awws_pkg.sv
package awws_pkg;

  localparam int unsigned DEF_MAX_SAMPLES = 16;
  localparam int unsigned DEF_MIN_SAMPLES = 4;
  localparam int unsigned DEF_WEIGHT_BITS = 24;

  localparam int unsigned CFG_BITS     = 16;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned WSIZE_BITS   = 5;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CHANGE_THR = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IGNORE_THR = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_BAND  = 2'd2;

  localparam logic [CFG_BITS-1:0] RST_CHANGE_THR = 16'd50;
  localparam logic [CFG_BITS-1:0] RST_IGNORE_THR = 16'd5;
  localparam logic [CFG_BITS-1:0] RST_ZERO_BAND  = 16'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_SLOT,
    ST_CHECK,
    ST_SUM,
    ST_SUM_TAIL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_SNAP,
    ST_DECIDE,
    ST_FILL,
    ST_EMIT
  } awws_state_e;

  typedef struct packed {
    logic accept;
    logic tare;
    logic rd_slot;
    logic store;
    logic sum_start;
    logic sum_step;
    logic div_load;
    logic div_step;
    logic snap;
    logic decide;
    logic fill_step;
    logic emit;
  } awws_cmd_t;

  typedef struct packed {
    logic tare;
    logic reject;
    logic sum_last;
    logic div_last;
    logic shrink;
    logic fill_last;
    logic out_full;
  } awws_status_t;

endpackage

>>> rtl/awws_in_if.sv
interface awws_in_if #(
  parameter int unsigned WEIGHT_BITS = awws_pkg::DEF_WEIGHT_BITS
);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [WEIGHT_BITS-1:0] raw_weight;

  modport source (output valid, op, raw_weight, input ready);
  modport sink (input valid, op, raw_weight, output ready);
endinterface

>>> rtl/awws_out_if.sv
interface awws_out_if #(
  parameter int unsigned WEIGHT_BITS = awws_pkg::DEF_WEIGHT_BITS
);
  logic                            valid;
  logic                            ready;
  logic signed [WEIGHT_BITS-1:0]   mean_weight;
  logic signed [WEIGHT_BITS-1:0]   stable_weight;
  logic                            weight_changed;
  logic [awws_pkg::WSIZE_BITS-1:0] window_size;

  modport source (output valid, mean_weight, stable_weight, weight_changed, window_size,
                  input ready);
  modport sink (input valid, mean_weight, stable_weight, weight_changed, window_size,
                output ready);
endinterface

>>> rtl/awws_ram.sv
module awws_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/awws_ctrl.sv
module awws_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  awws_pkg::awws_status_t status_i,
  output awws_pkg::awws_cmd_t    cmd_o
);
  import awws_pkg::*;

  awws_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RD_SLOT;
      end
      ST_RD_SLOT: begin
        state_d = status_i.tare ? ST_EMIT : ST_CHECK;
      end
      ST_CHECK: begin
        state_d = status_i.reject ? ST_EMIT : ST_SUM;
      end
      ST_SUM: begin
        if (status_i.sum_last) state_d = ST_SUM_TAIL;
      end
      ST_SUM_TAIL: state_d = ST_DIV_LOAD;
      ST_DIV_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_SNAP;
      end
      ST_SNAP:   state_d = ST_DECIDE;
      ST_DECIDE: begin
        state_d = status_i.shrink ? ST_FILL : ST_EMIT;
      end
      ST_FILL: begin
        if (status_i.fill_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.out_full) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_RD_SLOT: begin
        cmd_o.tare    = status_i.tare;
        cmd_o.rd_slot = !status_i.tare;
      end
      ST_CHECK: begin
        cmd_o.store     = !status_i.reject;
        cmd_o.sum_start = !status_i.reject;
      end
      ST_SUM:      cmd_o.sum_step  = 1'b1;
      ST_SUM_TAIL: cmd_o           = '0;
      ST_DIV_LOAD: cmd_o.div_load  = 1'b1;
      ST_DIV:      cmd_o.div_step  = 1'b1;
      ST_SNAP:     cmd_o.snap      = 1'b1;
      ST_DECIDE:   cmd_o.decide    = 1'b1;
      ST_FILL:     cmd_o.fill_step = 1'b1;
      ST_EMIT:     cmd_o.emit      = !status_i.out_full;
      default:     cmd_o           = '0;
    endcase
  end

endmodule

>>> rtl/awws_dp.sv
module awws_dp #(
  parameter int unsigned MAX_SAMPLES = awws_pkg::DEF_MAX_SAMPLES,
  parameter int unsigned MIN_SAMPLES = awws_pkg::DEF_MIN_SAMPLES,
  parameter int unsigned WEIGHT_BITS = awws_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [awws_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [awws_pkg::CFG_BITS-1:0]        cfg_data_i,
  input  awws_pkg::awws_cmd_t                  cmd_i,
  output awws_pkg::awws_status_t               status_o,
  input  logic                                 op_i,
  input  logic signed [WEIGHT_BITS-1:0]        raw_weight_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [WEIGHT_BITS-1:0]        mean_weight_o,
  output logic signed [WEIGHT_BITS-1:0]        stable_weight_o,
  output logic                                 weight_changed_o,
  output logic [awws_pkg::WSIZE_BITS-1:0]      window_size_o
);
  import awws_pkg::*;

  localparam int unsigned W        = WEIGHT_BITS;
  localparam int unsigned SLOT_BITS = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_BITS = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_BITS = WEIGHT_BITS + $clog2(MAX_SAMPLES) + 1;
  localparam int unsigned DIV_CNT_BITS = $clog2(SUM_BITS + 1);

  function automatic logic [W:0] abs_diff(logic signed [W-1:0] a, logic signed [W-1:0] b);
    logic signed [W:0] d;
    d = {a[W-1], a} - {b[W-1], b};
    return d[W] ? (W+1)'(-d) : (W+1)'(d);
  endfunction

  logic [CFG_BITS-1:0] chg_q, chg_d, ign_q, ign_d, band_q, band_d;

  logic [SLOT_BITS-1:0]   slot_q, slot_d;
  logic [CNT_BITS-1:0]    cnt_q, cnt_d;
  logic signed [W-1:0]    run_q, run_d;
  logic signed [W-1:0]    rep_q, rep_d;
  logic [MAX_SAMPLES-1:0] valid_q, valid_d;
  logic                   changed_q, changed_d;
  logic                   out_valid_q, out_valid_d;

  logic signed [W-1:0]        raw_q, raw_d;
  logic                       op_q, op_d;
  logic signed [SUM_BITS-1:0] acc_q, acc_d;
  logic [SLOT_BITS-1:0]       idx_q, idx_d;
  logic                       pend_q, pend_d;
  logic                       rd_valid_q;
  logic [CNT_BITS-1:0]        rem_q, rem_d;
  logic [SUM_BITS-1:0]        quo_q, quo_d;
  logic [DIV_CNT_BITS-1:0]    div_cnt_q, div_cnt_d;
  logic                       neg_q, neg_d;
  logic signed [W-1:0]        mean_q, mean_d;
  logic signed [W-1:0]        out_mean_q, out_mean_d, out_stable_q, out_stable_d;
  logic                       out_changed_q, out_changed_d;
  logic [CNT_BITS-1:0]        out_size_q, out_size_d;

  logic                 ram_we;
  logic [SLOT_BITS-1:0] ram_waddr, ram_raddr;
  logic [W-1:0]         ram_rdata;

  logic signed [W-1:0]        rd_w;
  logic signed [SUM_BITS-1:0] rd_ext;
  logic [CNT_BITS-1:0]        slot_inc;
  logic [SUM_BITS-1:0]        sum_abs;
  logic [CNT_BITS:0]          rem_sh;
  logic [CNT_BITS:0]          rem_sub;
  logic                       q_bit;
  logic [W-1:0]               qw;
  logic [W:0]                 chg_x, ign_x, d_run, d_rep;
  logic                       grow, shrink;

  assign chg_x = (W+1)'(chg_q);
  assign ign_x = (W+1)'(ign_q);

  assign rd_w   = rd_valid_q ? signed'(ram_rdata) : '0;
  assign rd_ext = SUM_BITS'(rd_w);

  assign slot_inc = CNT_BITS'(slot_q) + 1'b1;
  assign sum_abs  = acc_q[SUM_BITS-1] ? SUM_BITS'(-acc_q) : SUM_BITS'(acc_q);
  assign rem_sh   = {rem_q, quo_q[SUM_BITS-1]};
  assign rem_sub  = rem_sh - {1'b0, cnt_q};
  assign q_bit    = (rem_sh >= {1'b0, cnt_q});
  assign qw       = quo_q[W-1:0];

  assign d_run  = abs_diff(mean_q, run_q);
  assign d_rep  = abs_diff(rep_q, mean_q);
  assign grow   = (d_run > ign_x) && (d_run <= chg_x) && (cnt_q < CNT_BITS'(MAX_SAMPLES));
  assign shrink = !grow && (d_run > chg_x) && (cnt_q > CNT_BITS'(MIN_SAMPLES));

  always_comb begin
    status_o           = '0;
    status_o.tare      = op_q;
    status_o.reject    = (abs_diff(raw_q, run_q) < chg_x) || (abs_diff(rd_w, raw_q) <= ign_x);
    status_o.sum_last  = (CNT_BITS'(idx_q) == cnt_q - 1'b1);
    status_o.div_last  = (div_cnt_q == DIV_CNT_BITS'(SUM_BITS - 1));
    status_o.shrink    = shrink;
    status_o.fill_last = (CNT_BITS'(idx_q) == CNT_BITS'(MAX_SAMPLES - 1));
    status_o.out_full  = out_valid_q;
  end

  always_comb begin
    ram_we    = cmd_i.store || (cmd_i.decide && grow) || cmd_i.fill_step;
    ram_waddr = slot_q;
    if (cmd_i.decide) begin
      ram_waddr = SLOT_BITS'(cnt_q);
    end else if (cmd_i.fill_step) begin
      ram_waddr = idx_q;
    end
    ram_raddr = cmd_i.sum_step ? idx_q : slot_q;
  end

  awws_ram #(
    .WIDTH (W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (raw_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    chg_d  = chg_q;
    ign_d  = ign_q;
    band_d = band_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHANGE_THR: chg_d  = cfg_data_i;
        CFG_IGNORE_THR: ign_d  = cfg_data_i;
        CFG_ZERO_BAND:  band_d = cfg_data_i;
        default:        chg_d  = chg_q;
      endcase
    end
  end

  always_comb begin
    slot_d        = slot_q;
    cnt_d         = cnt_q;
    run_d         = run_q;
    rep_d         = rep_q;
    valid_d       = valid_q;
    changed_d     = changed_q;
    out_valid_d   = out_valid_q;
    raw_d         = raw_q;
    op_d          = op_q;
    acc_d         = acc_q;
    idx_d         = idx_q;
    pend_d        = cmd_i.sum_step;
    rem_d         = rem_q;
    quo_d         = quo_q;
    div_cnt_d     = div_cnt_q;
    neg_d         = neg_q;
    mean_d        = mean_q;
    out_mean_d    = out_mean_q;
    out_stable_d  = out_stable_q;
    out_changed_d = out_changed_q;
    out_size_d    = out_size_q;

    if (cmd_i.accept) begin
      raw_d     = raw_weight_i;
      op_d      = op_i;
      changed_d = 1'b0;
    end
    if (cmd_i.tare) begin
      valid_d = '0;
    end
    if (cmd_i.store) begin
      valid_d[slot_q] = 1'b1;
      if (slot_inc >= CNT_BITS'(MAX_SAMPLES) || slot_inc >= cnt_q) begin
        slot_d = '0;
      end else begin
        slot_d = SLOT_BITS'(slot_inc);
      end
    end
    if (cmd_i.sum_start) begin
      idx_d = '0;
      acc_d = '0;
    end
    if (cmd_i.sum_step) begin
      idx_d = idx_q + 1'b1;
    end
    if (pend_q) begin
      acc_d = acc_q + rd_ext;
    end
    if (cmd_i.div_load) begin
      quo_d     = sum_abs + SUM_BITS'(cnt_q >> 1);
      rem_d     = '0;
      div_cnt_d = '0;
      neg_d     = acc_q[SUM_BITS-1];
    end
    if (cmd_i.div_step) begin
      rem_d     = q_bit ? rem_sub[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];
      quo_d     = {quo_q[SUM_BITS-2:0], q_bit};
      div_cnt_d = div_cnt_q + 1'b1;
    end
    if (cmd_i.snap) begin
      if (quo_q < SUM_BITS'(band_q)) begin
        mean_d = '0;
      end else begin
        mean_d = neg_q ? signed'(-qw) : signed'(qw);
      end
    end
    if (cmd_i.decide) begin
      idx_d = '0;
      if (grow) begin
        cnt_d = cnt_q + 1'b1;
        valid_d[SLOT_BITS'(cnt_q)] = 1'b1;
      end else if (shrink) begin
        cnt_d = CNT_BITS'(MIN_SAMPLES);
      end
      if (d_run > ign_x) begin
        run_d = mean_q;
        if (d_rep > chg_x) begin
          rep_d     = mean_q;
          changed_d = 1'b1;
        end
      end
    end
    if (cmd_i.fill_step) begin
      idx_d          = idx_q + 1'b1;
      valid_d[idx_q] = 1'b1;
    end
    if (cmd_i.emit) begin
      out_valid_d   = 1'b1;
      out_mean_d    = run_q;
      out_stable_d  = rep_q;
      out_changed_d = changed_q;
      out_size_d    = cnt_q;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chg_q       <= RST_CHANGE_THR;
      ign_q       <= RST_IGNORE_THR;
      band_q      <= RST_ZERO_BAND;
      slot_q      <= '0;
      cnt_q       <= CNT_BITS'(MIN_SAMPLES);
      run_q       <= '0;
      rep_q       <= '0;
      valid_q     <= '0;
      changed_q   <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      chg_q       <= chg_d;
      ign_q       <= ign_d;
      band_q      <= band_d;
      slot_q      <= slot_d;
      cnt_q       <= cnt_d;
      run_q       <= run_d;
      rep_q       <= rep_d;
      valid_q     <= valid_d;
      changed_q   <= changed_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q         <= raw_d;
    op_q          <= op_d;
    acc_q         <= acc_d;
    idx_q         <= idx_d;
    rd_valid_q    <= valid_q[ram_raddr];
    rem_q         <= rem_d;
    quo_q         <= quo_d;
    div_cnt_q     <= div_cnt_d;
    neg_q         <= neg_d;
    mean_q        <= mean_d;
    out_mean_q    <= out_mean_d;
    out_stable_q  <= out_stable_d;
    out_changed_q <= out_changed_d;
    out_size_q    <= out_size_d;
  end

  assign out_valid_o      = out_valid_q;
  assign mean_weight_o    = out_mean_q;
  assign stable_weight_o  = out_stable_q;
  assign weight_changed_o = out_changed_q;
  assign window_size_o    = WSIZE_BITS'(out_size_q);

endmodule

>>> rtl/adaptive_window_weight_smoother_core.sv
// Smooths signed load-cell samples with an adaptive windowed mean and returns one result
// item for every input item. A tare goes from the slot read straight to the output, and a
// sample that is rejected as noise passes the check first. An accepted sample is stored,
// then summed over the current window, read from the sample memory one entry per cycle,
// then divided by a bit-serial divider of S = WEIGHT_BITS + log2(MAX_SAMPLES) + 1 steps
// that forms the rounded mean, and then snapped to zero or not and used for the window
// decision; when a large step shrinks the window, a refill writes the sample to every
// memory entry, one per cycle. A new item is taken while the previous result still waits
// on the output, and an item stays in its last state until the previous result has been
// taken. Configuration must be written only while the block is idle; the block itself does not enforce this.
module adaptive_window_weight_smoother_core #(
  parameter int unsigned MAX_SAMPLES = awws_pkg::DEF_MAX_SAMPLES,
  parameter int unsigned MIN_SAMPLES = awws_pkg::DEF_MIN_SAMPLES,
  parameter int unsigned WEIGHT_BITS = awws_pkg::DEF_WEIGHT_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [awws_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [awws_pkg::CFG_BITS-1:0]     cfg_data_i,
  awws_in_if.sink                           in_i,
  awws_out_if.source                        out_o
);
  import awws_pkg::*;

  awws_cmd_t    cmd;
  awws_status_t status;

  awws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  awws_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MIN_SAMPLES (MIN_SAMPLES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .op_i             (in_i.op),
    .raw_weight_i     (in_i.raw_weight),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .mean_weight_o    (out_o.mean_weight),
    .stable_weight_o  (out_o.stable_weight),
    .weight_changed_o (out_o.weight_changed),
    .window_size_o    (out_o.window_size)
  );

endmodule

>>> verif/adaptive_window_weight_smoother_core_test.sv
`timescale 1ns / 100ps

module adaptive_window_weight_smoother_core_test;
  import awws_pkg::*;

  localparam int WB        = DEF_WEIGHT_BITS;
  localparam int MAXS      = DEF_MAX_SAMPLES;
  localparam int MINS      = DEF_MIN_SAMPLES;
  localparam int N_DIR     = 22;
  localparam int N_PHASES  = 8;
  localparam int PER_PHASE = 119;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TARE   = 1'b1;

  localparam longint W_MAX = (longint'(1) <<< (WB - 1)) - 1;
  localparam longint W_MIN = -(longint'(1) <<< (WB - 1));

  typedef struct packed {
    logic signed [WB-1:0]  mean;
    logic signed [WB-1:0]  stable;
    logic                  changed;
    logic [WSIZE_BITS-1:0] wsize;
  } smooth_res_t;

  typedef struct packed {
    logic        op;
    logic [23:0] raw;
    logic        typed;
    smooth_res_t want;
  } dir_row_t;

  // Rows with typed results start from reset thresholds; the rest rely on the predictor.
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{OP_SAMPLE, 24'h000000, 1'b1, '{24'h000000, 24'h000000, 1'b0, 5'd4}},
    '{OP_TARE,   24'h000000, 1'b1, '{24'h000000, 24'h000000, 1'b0, 5'd4}},
    '{OP_SAMPLE, 24'd49,     1'b1, '{24'h000000, 24'h000000, 1'b0, 5'd4}},
    '{OP_SAMPLE, 24'h7FFFFF, 1'b1, '{24'h200000, 24'h200000, 1'b1, 5'd4}},
    '{OP_TARE,   24'hFFFFFF, 1'b1, '{24'h200000, 24'h200000, 1'b0, 5'd4}},
    '{OP_SAMPLE, 24'd3,      1'b1, '{24'h200000, 24'h200000, 1'b0, 5'd4}},
    '{OP_SAMPLE, 24'h800000, 1'b1, '{24'hE00000, 24'hE00000, 1'b1, 5'd4}},
    '{OP_SAMPLE, 24'd100,    1'b0, '0},
    '{OP_SAMPLE, 24'd200,    1'b0, '0},
    '{OP_SAMPLE, 24'd200,    1'b0, '0},
    '{OP_SAMPLE, 24'd260,    1'b0, '0},
    '{OP_SAMPLE, 24'd320,    1'b0, '0},
    '{OP_SAMPLE, 24'd380,    1'b0, '0},
    '{OP_TARE,   24'h000000, 1'b0, '0},
    '{OP_SAMPLE, 24'd16,     1'b0, '0},
    '{OP_SAMPLE, 24'hFFFFC4, 1'b0, '0},
    '{OP_SAMPLE, 24'h7FFFFF, 1'b0, '0},
    '{OP_SAMPLE, 24'h800000, 1'b0, '0},
    '{OP_SAMPLE, 24'hFFFFFF, 1'b0, '0},
    '{OP_SAMPLE, 24'h7FFFFF, 1'b0, '0},
    '{OP_TARE,   24'h7FFFFF, 1'b0, '0},
    '{OP_SAMPLE, 24'h000000, 1'b0, '0}
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [CFG_BITS-1:0]     cfg_data_i;

  awws_in_if  #(.WEIGHT_BITS(WB)) in_if ();
  awws_out_if #(.WEIGHT_BITS(WB)) out_if ();

  adaptive_window_weight_smoother_core #(
    .MAX_SAMPLES(MAXS),
    .MIN_SAMPLES(MINS),
    .WEIGHT_BITS(WB)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  longint sample_mem [MAXS];
  longint wr_slot, win_len, avg_now, held_weight;
  longint thr_change, thr_ignore, band_zero;

  smooth_res_t pending_means [$];
  logic        row_typed;
  smooth_res_t row_want;
  int          send_idle_pct;
  int          stall_pct;
  int          err_cnt, res_cnt, sent_cnt;
  int          tare_cnt, grow_cnt, shrink_cnt, snap_cnt, change_cnt, widest;

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void smoother_reset();
    foreach (sample_mem[i]) sample_mem[i] = 0;
    wr_slot     = 0;
    win_len     = MINS;
    avg_now     = 0;
    held_weight = 0;
    thr_change  = RST_CHANGE_THR;
    thr_ignore  = RST_IGNORE_THR;
    band_zero   = RST_ZERO_BAND;
  endfunction

  function automatic smooth_res_t smooth_step(input logic op, input logic signed [WB-1:0] raw_in);
    longint      raw, sum, q, m, d;
    logic        upd;
    smooth_res_t r;
    raw = raw_in;
    upd = 1'b0;
    if (op == OP_TARE) begin
      foreach (sample_mem[i]) sample_mem[i] = 0;
      tare_cnt++;
    end else begin
      if (wr_slot >= MAXS) wr_slot = 0;
      if (mag(raw - avg_now) >= thr_change && mag(sample_mem[wr_slot] - raw) > thr_ignore) begin
        sample_mem[wr_slot] = raw;
        wr_slot++;
        if (wr_slot >= MAXS || wr_slot >= win_len) wr_slot = 0;
        sum = 0;
        for (int i = 0; i < win_len && i < MAXS; i++) sum += sample_mem[i];
        q = (mag(sum) + win_len / 2) / win_len;
        m = (sum < 0) ? -q : q;
        if (mag(m) < band_zero) begin
          if (m != 0) snap_cnt++;
          m = 0;
        end
        d = mag(m - avg_now);
        if (d > thr_ignore && d <= thr_change && win_len < MAXS) begin
          win_len++;
          sample_mem[(win_len - 1) % MAXS] = raw;
          grow_cnt++;
        end else if (d > thr_change && win_len > MINS) begin
          win_len = MINS;
          foreach (sample_mem[i]) sample_mem[i] = raw;
          shrink_cnt++;
        end
        if (d > thr_ignore) begin
          avg_now = m;
          if (mag(held_weight - m) > thr_change) begin
            held_weight = m;
            upd = 1'b1;
            change_cnt++;
          end
        end
      end
    end
    if (win_len > widest) widest = win_len;
    r.mean    = avg_now[WB-1:0];
    r.stable  = held_weight[WB-1:0];
    r.changed = upd;
    r.wsize   = win_len[WSIZE_BITS-1:0];
    return r;
  endfunction

  // Most samples sit a chosen distance from the running mean or from the slot
  // about to be overwritten, so that every threshold decision is exercised.
  function automatic logic signed [WB-1:0] pick_sample();
    longint v, t, base;
    int     k;
    k = $urandom_range(99);
    if (k < 10) begin
      v = $urandom;
      return v[WB-1:0];
    end
    if (k < 25) begin
      t    = $urandom_range(0, int'(thr_ignore) + 2);
      base = sample_mem[wr_slot % MAXS];
    end else begin
      if (k < 65) t = $urandom_range(int'(thr_ignore), int'(thr_change) + 2);
      else t = $urandom_range(int'(thr_change), 3 * int'(thr_change) + 64);
      if ($urandom_range(1)) t = t * $urandom_range(1, int'(win_len));
      base = avg_now;
    end
    v = $urandom_range(1) ? base - t : base + t;
    if (v > W_MAX) v = W_MAX;
    if (v < W_MIN) v = W_MIN;
    return v[WB-1:0];
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  task automatic cmp_field(input string name, input logic signed [63:0] got,
                           input logic signed [63:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d %s: expected %0d, got %0d", res_cnt, name, want, got));
  endtask

  task automatic check_result();
    smooth_res_t w;
    if (pending_means.size() == 0) begin
      flag_error($sformatf("result %0d arrived with nothing expected", res_cnt));
    end else begin
      w = pending_means.pop_front();
      cmp_field("mean_weight", out_if.mean_weight, w.mean);
      cmp_field("stable_weight", out_if.stable_weight, w.stable);
      cmp_field("weight_changed", {63'd0, out_if.weight_changed}, {63'd0, w.changed});
      cmp_field("window_size", {59'd0, out_if.window_size}, {59'd0, w.wsize});
    end
    res_cnt++;
  endtask

  task automatic send_item(input logic op, input logic signed [WB-1:0] raw,
                           input logic typed, input smooth_res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.op         <= op;
    in_if.raw_weight <= raw;
    row_typed = typed;
    row_want  = want;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent_cnt++;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_means.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_thresholds(input int chg, input int ign, input int band);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CHANGE_THR;
    cfg_data_i <= chg[CFG_BITS-1:0];
    @(negedge clk_i);
    cfg_idx_i  <= CFG_IGNORE_THR;
    cfg_data_i <= ign[CFG_BITS-1:0];
    @(negedge clk_i);
    cfg_idx_i  <= CFG_ZERO_BAND;
    cfg_data_i <= band[CFG_BITS-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    thr_change = chg;
    thr_ignore = ign;
    band_zero  = band;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("adaptive_window_weight_smoother_core_test: errors");
    $finish;
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : monitor
    smooth_res_t nxt;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        nxt = smooth_step(in_if.op, in_if.raw_weight);
        pending_means.push_back(row_typed ? row_want : nxt);
      end
      if (out_if.valid && out_if.ready) check_result();
    end
  end

  initial begin : stimulus
    logic op;
    int   chg, ign, band;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_CHANGE_THR;
    cfg_data_i       = '0;
    in_if.valid      = 1'b0;
    in_if.op         = OP_SAMPLE;
    in_if.raw_weight = '0;
    row_typed        = 1'b0;
    row_want         = '0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    smoother_reset();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIR_ROWS[i])
      send_item(DIR_ROWS[i].op, DIR_ROWS[i].raw, DIR_ROWS[i].typed, DIR_ROWS[i].want);

    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      case (p)
        0: set_thresholds(50, 5, 5);
        1: set_thresholds(0, 0, 0);
        2: set_thresholds(65535, 65535, 65535);
        3: set_thresholds(400, 12, 40);
        4: set_thresholds(20, 0, 65535);
        5: set_thresholds(65535, 0, 0);
        6: set_thresholds(3000, 100, 2);
        default: begin
          chg  = $urandom_range(0, 3000);
          ign  = $urandom_range(0, chg / 3);
          band = $urandom_range(0, 500);
          set_thresholds(chg, ign, band);
        end
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 62; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 62; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      for (int n = 0; n < PER_PHASE; n++) begin
        op = ($urandom_range(99) < 4) ? OP_TARE : OP_SAMPLE;
        send_item(op, (op == OP_TARE) ? WB'($urandom) : pick_sample(), 1'b0, '0);
      end
    end

    wait_idle();
    stall_pct = 0;
    repeat (100) @(negedge clk_i);

    $display("Sent %0d items (%0d tares) over %0d threshold settings; %0d results, %0d mismatches.",
             sent_cnt, tare_cnt, N_PHASES + 1, res_cnt, err_cnt);
    $display("Window grew %0d times, shrank %0d times, reached %0d; %0d snaps, %0d stable updates.",
             grow_cnt, shrink_cnt, widest, snap_cnt, change_cnt);
    if (err_cnt == 0) begin
      $display("adaptive_window_weight_smoother_core_test: clean");
    end else begin
      $display("adaptive_window_weight_smoother_core_test: errors");
    end
    $finish;
  end

endmodule

>>> adaptive_window_weight_smoother_core.f
rtl/awws_pkg.sv
rtl/awws_in_if.sv
rtl/awws_out_if.sv
rtl/awws_ram.sv
rtl/awws_ctrl.sv
rtl/awws_dp.sv
rtl/adaptive_window_weight_smoother_core.sv
verif/adaptive_window_weight_smoother_core_test.sv
